FILE: src/cpt_pkg.sv
package cpt_pkg;

    localparam int MAX_V     = 16;
    localparam int CNT_W     = $clog2(MAX_V + 1);
    localparam int LAST_STEP = MAX_V + 2;
    localparam int STEP_W    = $clog2(LAST_STEP + 1);

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_TEST  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } t_vtx;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

FILE: src/cpt_cell.sv
module cpt_cell (
    input  logic              i_clk,
    input  cpt_pkg::t_cell_ctl i_ctl,
    input  cpt_pkg::t_vtx     i_nbr,
    input  cpt_pkg::t_vtx     i_wdata,
    output cpt_pkg::t_vtx     o_vtx
);
    import cpt_pkg::*;

    t_vtx r_vtx;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_vtx <= i_nbr;
        end else if (i_ctl.load) begin
            r_vtx <= i_wdata;
        end
    end

    assign o_vtx = r_vtx;

endmodule

FILE: src/cpt_cross.sv
module cpt_cross (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_issue,
    input  cpt_pkg::t_vtx      i_start,
    input  cpt_pkg::t_vtx      i_end,
    input  logic signed [16:0] i_px,
    input  logic signed [16:0] i_py,
    output logic               o_rej_valid,
    output logic               o_reject
);
    import cpt_pkg::*;

    logic               r_v1;
    logic               r_v2;
    logic signed [16:0] r_ex;
    logic signed [16:0] r_ey;
    logic signed [17:0] r_qx;
    logic signed [17:0] r_qy;
    logic signed [34:0] r_p1;
    logic signed [34:0] r_p2;
    logic signed [35:0] w_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ex <= 17'(i_end.x) - 17'(i_start.x);
        r_ey <= 17'(i_end.y) - 17'(i_start.y);
        r_qx <= 18'(i_px) - 18'(i_start.x);
        r_qy <= 18'(i_py) - 18'(i_start.y);
        r_p1 <= 35'(r_ex) * 35'(r_qy);
        r_p2 <= 35'(r_ey) * 35'(r_qx);
    end

    assign w_diff      = 36'(r_p1) - 36'(r_p2);
    assign o_rej_valid = r_v2;
    assign o_reject    = w_diff[35];

endmodule

FILE: src/convex_polygon_point_test_core.sv
// Convex polygon point test.
// Input channel i_in_valid / o_in_ready carries one item: opcode, coord_x, coord_y.
// Output channel o_out_valid / i_out_ready returns one result per item:
// inside_res, status and count_now.
// Clear and add do not run the ring; their result shows the cycle after accept.
// A test rotates the 16-cell vertex ring once through a single pipelined
// cross-product unit, one test at a time; the ring rotation length and the
// two-stage multiplier pipeline set how long a test runs before its result.
// Write origin_x (index 0) and origin_y (index 1) through i_cfg_we while idle.
// Reset empties the vertex table and clears the origin; stored vertices
// stay undefined until added.
// When the receiver stalls the result holds in the output register and the
// input is held off; the next item can be taken in the cycle that the
// waiting result leaves.
module convex_polygon_point_test_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_opcode,
    input  logic signed [15:0] i_coord_x,
    input  logic signed [15:0] i_coord_y,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_inside_res,
    output logic [1:0]         o_status,
    output logic [4:0]         o_count_now,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import cpt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]         r_state;
    logic [STEP_W-1:0]  r_step;
    logic [CNT_W-1:0]   r_count;
    logic signed [15:0] r_org_x;
    logic signed [15:0] r_org_y;
    logic signed [16:0] r_px;
    logic signed [16:0] r_py;
    t_vtx               r_v0;
    t_vtx               r_prev;
    logic               r_inside;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               r_out_inside;
    logic [1:0]         r_out_status;
    logic [CNT_W-1:0]   r_out_count;

    t_vtx               w_vtx [MAX_V];
    t_vtx               w_wdata;
    t_vtx               w_start;
    logic               w_accept;
    logic               w_slot_free;
    logic               w_shift;
    logic               w_issue;
    logic               w_rej_valid;
    logic               w_reject;
    logic               w_full;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && w_slot_free;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_full      = (r_count == CNT_W'(MAX_V));
    assign w_wdata     = '{x: i_coord_x, y: i_coord_y};

    assign w_shift = (r_state == S_RUN) && (r_step < STEP_W'(MAX_V));
    assign w_issue = (r_state == S_RUN) && (r_step != '0)
                     && (r_step <= STEP_W'(r_count));
    assign w_start = (r_step == STEP_W'(r_count)) ? r_v0 : w_vtx[0];

    for (genvar j = 0; j < MAX_V; j++) begin : g_cell
        t_cell_ctl w_ctl;
        assign w_ctl.shift = w_shift;
        assign w_ctl.load  = w_accept && (i_opcode == OP_ADD) && !w_full
                             && (r_count == CNT_W'(j));
        cpt_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_nbr   (w_vtx[(j + 1) % MAX_V]),
            .i_wdata (w_wdata),
            .o_vtx   (w_vtx[j])
        );
    end

    cpt_cross u_cross (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (w_issue),
        .i_start     (w_start),
        .i_end       (r_prev),
        .i_px        (r_px),
        .i_py        (r_py),
        .o_rej_valid (w_rej_valid),
        .o_reject    (w_reject)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index) begin
                r_org_y <= i_cfg_data;
            end else begin
                r_org_x <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_accept && !((i_opcode == OP_TEST) && (r_count != '0))) begin
            n_out_valid = 1'b1;
        end
        if ((r_state == S_DONE) && w_slot_free) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_out_inside <= 1'b0;
                        case (i_opcode)
                            OP_CLEAR: begin
                                r_count      <= '0;
                                r_out_status <= ST_OK;
                                r_out_count  <= '0;
                            end
                            OP_ADD: begin
                                if (w_full) begin
                                    r_out_status <= ST_FULL;
                                    r_out_count  <= r_count;
                                end else begin
                                    r_count      <= r_count + 1'b1;
                                    r_out_status <= ST_OK;
                                    r_out_count  <= r_count + 1'b1;
                                end
                            end
                            OP_TEST: begin
                                if (r_count == '0) begin
                                    r_out_status <= ST_EMPTY;
                                    r_out_count  <= r_count;
                                end else begin
                                    r_px        <= 17'(i_coord_x) - 17'(r_org_x);
                                    r_py        <= 17'(i_coord_y) - 17'(r_org_y);
                                    r_inside    <= 1'b1;
                                    r_step      <= '0;
                                    r_state     <= S_RUN;
                                end
                            end
                            default: begin
                                r_out_status <= ST_OK;
                                r_out_count  <= r_count;
                            end
                        endcase
                    end
                end
                S_RUN: begin
                    if (r_step == '0) begin
                        r_v0 <= w_vtx[0];
                    end
                    r_prev <= w_vtx[0];
                    if (w_rej_valid && w_reject) begin
                        r_inside <= 1'b0;
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(LAST_STEP)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_slot_free) begin
                        r_out_inside <= r_inside;
                        r_out_status <= ST_OK;
                        r_out_count  <= r_count;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_inside_res = r_out_inside;
    assign o_status     = r_out_status;
    assign o_count_now  = 5'(r_out_count);

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import cpt_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam logic REG_ORIGIN_X = 1'b0;
    localparam logic REG_ORIGIN_Y = 1'b1;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 238;
    localparam int SETTLE_CYCLES   = 30;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam real TWO_PI         = 6.283185307179586;

    typedef struct {
        logic       in_poly;
        logic [1:0] status;
        logic [4:0] count;
    } t_result;

    // Reference of the vertex table and the queue of results it predicts.
    class polygon_scoreboard;
        logic signed [15:0] org_x;
        logic signed [15:0] org_y;
        logic signed [15:0] vx [MAX_V];
        logic signed [15:0] vy [MAX_V];
        int                 nvert;
        t_result            expected_q [$];
        int                 errors;

        function new();
            org_x  = '0;
            org_y  = '0;
            nvert  = 0;
            errors = 0;
        endfunction

        function void set_origin(logic signed [15:0] x, logic signed [15:0] y);
            org_x = x;
            org_y = y;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Negative cross product of edge a->b against the origin-relative point.
        function bit edge_rejects(int a, int b, longint px, longint py);
            longint ex, ey, qx, qy;
            ex = longint'(vx[b]) - longint'(vx[a]);
            ey = longint'(vy[b]) - longint'(vy[a]);
            qx = px - longint'(vx[a]);
            qy = py - longint'(vy[a]);
            return (ex * qy - ey * qx) < 0;
        endfunction

        function void note_item(logic [1:0] op, logic signed [15:0] x,
                                logic signed [15:0] y);
            t_result r;
            longint  px, py;
            int      i;
            r.in_poly = 1'b0;
            r.status  = ST_OK;
            case (op)
                OP_CLEAR: nvert = 0;
                OP_ADD: begin
                    if (nvert >= MAX_V) begin
                        r.status = ST_FULL;
                    end else begin
                        vx[nvert] = x;
                        vy[nvert] = y;
                        nvert++;
                    end
                end
                OP_TEST: begin
                    if (nvert == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        px = longint'(x) - longint'(org_x);
                        py = longint'(y) - longint'(org_y);
                        r.in_poly = 1'b1;
                        // newer to older, then the closing edge oldest to newest
                        for (i = nvert - 1; i >= 1 && r.in_poly; i--)
                            if (edge_rejects(i, i - 1, px, py))
                                r.in_poly = 1'b0;
                        if (r.in_poly && edge_rejects(0, nvert - 1, px, py))
                            r.in_poly = 1'b0;
                    end
                end
                default: ;
            endcase
            r.count = 5'(nvert);
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, int exp_v, int act_v);
            if (exp_v != act_v) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic in_poly, logic [1:0] status, logic [4:0] count);
            t_result r;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %0d/%0d/%0d",
                         $time, in_poly, status, count);
                errors++;
                return;
            end
            r = expected_q.pop_front();
            compare_field("inside_res", r.in_poly, in_poly);
            compare_field("status", r.status, status);
            compare_field("count_now", r.count, count);
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_opcode;
    logic signed [15:0] i_coord_x;
    logic signed [15:0] i_coord_y;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_inside_res;
    logic [1:0]         o_status;
    logic [4:0]         o_count_now;
    logic               i_cfg_we;
    logic               i_cfg_index;
    logic [15:0]        i_cfg_data;

    polygon_scoreboard sb;
    int                items_sent = 0;
    int                burst_left = 0;
    int                cycles = 0;
    int                stall_mode = 0;
    int                stall_left = 0;

    convex_polygon_point_test_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_inside_res (o_inside_res),
        .o_status     (o_status),
        .o_count_now  (o_count_now),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("** convex_polygon_point_test_core: FAILED **");
            $finish;
        end
    end

    // Result side: check on handshake, stall in modes of random length.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_inside_res, o_status, o_count_now);
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= ($urandom_range(0, 3) != 0);
            2:       i_out_ready <= ($urandom_range(0, 1) != 0);
            default: i_out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    function automatic logic signed [15:0] clamp16(int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(13, 40)) @(posedge i_clk);
            else
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    task automatic send_item(logic [1:0] op, logic signed [15:0] x,
                             logic signed [15:0] y);
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_coord_x  <= x;
        i_coord_y  <= y;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        sb.note_item(op, x, y);
        if (op != OP_NONE)
            items_sent++;
        pace_sender();
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_origin(logic signed [15:0] x, logic signed [15:0] y);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_ORIGIN_X;
        i_cfg_data  <= x;
        @(posedge i_clk);
        i_cfg_index <= REG_ORIGIN_Y;
        i_cfg_data  <= y;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_origin(x, y);
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n)
            send_item(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
    endtask

    // Clear, load a roughly regular polygon, then test points around it.
    task automatic polygon_session();
        int  k, kk, j, sel, rad, cen_x, cen_y, ox, oy, ntests, lim;
        int  px [18];
        int  py [18];
        real a0, dir, ang;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            k = $urandom_range(3, 8);
        else if (sel < 9)
            k = $urandom_range(9, 16);
        else
            k = $urandom_range(1, 2);
        if ($urandom_range(0, 11) == 0)
            k = $urandom_range(16, 18);
        kk = (k > MAX_V) ? MAX_V : k;
        sel = $urandom_range(0, 3);
        if (sel == 0)
            rad = $urandom_range(1, 50);
        else if (sel == 3)
            rad = $urandom_range(5000, 30000);
        else
            rad = $urandom_range(50, 5000);
        cen_x = int'($urandom_range(0, 40000)) - 20000;
        cen_y = int'($urandom_range(0, 40000)) - 20000;
        a0  = TWO_PI * $urandom_range(0, 999) / 1000.0;
        dir = $urandom_range(0, 1) ? 1.0 : -1.0;
        for (j = 0; j < k; j++) begin
            ang   = a0 + dir * TWO_PI * (j + $urandom_range(0, 40) / 100.0) / k;
            px[j] = clamp16(cen_x + int'(rad * $cos(ang)));
            py[j] = clamp16(cen_y + int'(rad * $sin(ang)));
        end

        send_item(OP_CLEAR, 16'($urandom), 16'($urandom));
        for (j = 0; j < k; j++)
            send_item(OP_ADD, 16'(px[j]), 16'(py[j]));

        ntests = $urandom_range(1, 10);
        repeat (ntests) begin
            sel = $urandom_range(0, 9);
            j   = $urandom_range(0, kk - 1);
            lim = rad + rad / 2;
            if (sel <= 2) begin
                ox = cen_x + int'($urandom_range(0, rad / 2)) - rad / 4;
                oy = cen_y + int'($urandom_range(0, rad / 2)) - rad / 4;
            end else if (sel == 3) begin
                ox = px[j];
                oy = py[j];
            end else if (sel == 4) begin
                ox = (px[j] + px[(j + 1) % kk]) / 2;
                oy = (py[j] + py[(j + 1) % kk]) / 2;
            end else if (sel <= 7) begin
                ox = cen_x + int'($urandom_range(0, 2 * lim)) - lim;
                oy = cen_y + int'($urandom_range(0, 2 * lim)) - lim;
            end else begin
                ox = int'(16'sh0 + $signed(16'($urandom))) - int'(sb.org_x);
                oy = int'(16'sh0 + $signed(16'($urandom))) - int'(sb.org_y);
            end
            send_item(OP_TEST, clamp16(ox + int'(sb.org_x)), clamp16(oy + int'(sb.org_y)));
        end
    endtask

    task automatic directed_items();
        int j;
        send_item(OP_TEST, 16'sh0000, 16'sh0000);
        send_item(OP_NONE, 16'shffff, 16'shffff);
        send_item(OP_ADD, 16'sh8000, 16'sh8000);
        send_item(OP_TEST, 16'sh7fff, 16'sh8000);
        send_item(OP_TEST, 16'sh8000, 16'sh7fff);
        send_item(OP_NONE, 16'sh7fff, 16'sh8000);
        send_item(OP_ADD, 16'sh7fff, 16'sh8000);
        send_item(OP_ADD, 16'sh7fff, 16'sh7fff);
        send_item(OP_ADD, 16'sh8000, 16'sh7fff);
        send_item(OP_TEST, 16'sh8000, 16'sh7fff);
        send_item(OP_TEST, 16'sh7fff, 16'sh8000);
        for (j = 0; j < MAX_V - 4; j++)
            send_item(OP_ADD, clamp16(-30000 + j * 5000), j[0] ? 16'sh7fff : 16'sh8000);
        send_item(OP_ADD, 16'sh1234, 16'sh4321);
        send_item(OP_TEST, 16'sh0000, 16'sh0000);
        send_item(OP_CLEAR, 16'sh0000, 16'sh0000);
        send_item(OP_TEST, 16'sh7fff, 16'sh7fff);
    endtask

    initial begin
        logic signed [15:0] org_xs [PHASES];
        logic signed [15:0] org_ys [PHASES];
        int                 p, phase_end;

        sb = new();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_opcode    <= OP_CLEAR;
        i_coord_x   <= '0;
        i_coord_y   <= '0;
        i_out_ready <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= REG_ORIGIN_X;
        i_cfg_data  <= '0;

        org_xs = '{16'sh0000, 16'sh8000, 16'sh7fff, 16'sh7fff,
                   16'($urandom), 16'($urandom_range(0, 200) - 100), 16'($urandom), 16'sh0000};
        org_ys = '{16'sh0000, 16'sh8000, 16'sh7fff, 16'sh8000,
                   16'($urandom), 16'($urandom_range(0, 200) - 100), 16'($urandom), 16'sh0005};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_origin(16'sh8000, 16'sh7fff);
        directed_items();

        for (p = 0; p < PHASES; p++) begin
            wait_drained();
            write_origin(org_xs[p], org_ys[p]);
            burst_left = 0;
            phase_end  = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 6) == 0)
                    send_noise();
                else
                    polygon_session();
            end
        end

        wait_drained();
        if (sb.errors == 0)
            $display("** convex_polygon_point_test_core: PASSED **");
        else
            $display("** convex_polygon_point_test_core: FAILED **");
        $finish;
    end

endmodule
